@@ design/vsr_pkg.sv @@
package vsr_pkg;

  // Default depth of the sprite attribute memory
  localparam int unsigned SPRITE_RAM_BYTES_DEF = 256;

  // Item kinds
  localparam logic [2:0] MODE_BUS_RD    = 3'd0;
  localparam logic [2:0] MODE_BUS_WR    = 3'd1;
  localparam logic [2:0] MODE_MEM_RET   = 3'd2;
  localparam logic [2:0] MODE_FRAME     = 3'd3;
  localparam logic [2:0] MODE_LINE      = 3'd4;
  localparam logic [2:0] MODE_VBL_START = 3'd5;
  localparam logic [2:0] MODE_VBL_END   = 3'd6;

  // Register indexes
  localparam logic [2:0] REG_CTRL     = 3'd0;
  localparam logic [2:0] REG_MASK     = 3'd1;
  localparam logic [2:0] REG_STATUS   = 3'd2;
  localparam logic [2:0] REG_SPR_PTR  = 3'd3;
  localparam logic [2:0] REG_SPR_DATA = 3'd4;
  localparam logic [2:0] REG_SCROLL   = 3'd5;
  localparam logic [2:0] REG_ADDR     = 3'd6;
  localparam logic [2:0] REG_DATA     = 3'd7;

  // Video memory request codes
  localparam logic [1:0] MEM_REQ_NONE = 2'd0;
  localparam logic [1:0] MEM_REQ_RD   = 2'd1;
  localparam logic [1:0] MEM_REQ_WR   = 2'd2;

  // Scroll address field masks
  localparam logic [15:0] TMP_NT_KEEP     = 16'hF3FF;
  localparam logic [15:0] TMP_CX_KEEP     = 16'hFFE0;
  localparam logic [15:0] TMP_CY_KEEP     = 16'hFC1F;
  localparam logic [15:0] TMP_FY_KEEP     = 16'h8FFF;
  localparam logic [15:0] TMP_LO_KEEP     = 16'h00FF;
  localparam logic [15:0] TMP_HI_KEEP     = 16'hFF00;
  localparam logic [15:0] CUR_VERT_KEEP   = 16'hFBE0;
  localparam logic [15:0] TMP_HORIZ       = 16'h041F;
  localparam logic [15:0] FINE_Y_FIELD    = 16'h7000;
  localparam logic [15:0] COARSE_Y_FIELD  = 16'h03E0;
  localparam logic [15:0] COARSE_Y_ROW29  = 16'h03A0;
  localparam logic [15:0] NT_VERT_FLIP    = 16'h0800;
  localparam logic [15:0] FINE_Y_ONE      = 16'h1000;
  localparam logic [15:0] COARSE_Y_ONE    = 16'h0020;

  typedef struct packed {
    logic [2:0] mode;
    logic [2:0] reg_sel;
    logic [7:0] wdata;
    logic       hit_report;
    logic       overflow_report;
  } vsr_in_t;

  typedef struct packed {
    logic [7:0]  rdata;
    logic [1:0]  mem_req;
    logic [13:0] mem_addr;
    logic [7:0]  mem_wdata;
    logic        nmi_on_vblank;
    logic [8:0]  line_number;
  } vsr_out_t;

  // Sprite memory write port
  typedef struct packed {
    logic       en;
    logic [7:0] idx;
    logic [7:0] data;
  } vsr_spr_wr_t;

endpackage

@@ design/video_scroll_register_file.sv @@
// Scroll register file of a tile video processor. Every input beat (a bus
// read or write, a returned video memory byte or a frame event) yields one
// result beat, registered on the output side; a new beat is taken every cycle
// while the result register is empty or being drained, so the sustained rate
// is one beat per cycle, each result showing in the cycle after its beat. The
// sprite attribute memory has one write port; entry zero is read every cycle
// through a register and a write to it is forwarded to the scanline check.
// The memory is not cleared at reset: no clearing pass delays the first beat.
module video_scroll_register_file
  import vsr_pkg::*;
#(
  parameter int unsigned SPRITE_RAM_BYTES = SPRITE_RAM_BYTES_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  vsr_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output vsr_out_t out_data
);

  vsr_spr_wr_t spr_wr;
  vsr_out_t    res;
  vsr_out_t    out_data_r;
  logic        out_valid_r;
  logic [7:0]  spr0;
  logic        in_acc;

  assign in_ready = !out_valid_r || out_ready;
  assign in_acc   = in_valid && in_ready;

  vsr_sprite_mem #(.BYTES(SPRITE_RAM_BYTES)) u_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (spr_wr),
    .spr0  (spr0)
  );

  vsr_core #(.BYTES(SPRITE_RAM_BYTES)) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (in_acc),
    .item   (in_data),
    .spr0   (spr0),
    .spr_wr (spr_wr),
    .res    (res)
  );

  // Hold the result beat until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Control write shows its interrupt enable in the next result
  a_ctrl_nmi: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_data.mode == MODE_BUS_WR && in_data.reg_sel == REG_CTRL
    |=> out_data.nmi_on_vblank == $past(in_data.wdata[7]))
    else $error("interrupt enable does not follow control write");

  // Frame start restarts the line counter
  a_frame_line: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_data.mode == MODE_FRAME |=> out_data.line_number == 9'd0)
    else $error("line counter not cleared at frame start");

  // Only bus reads return data
  a_rdata_zero: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_data.mode != MODE_BUS_RD |=> out_data.rdata == 8'd0)
    else $error("read data on a beat that is not a bus read");

  // Memory writes only come from data port writes
  a_mem_wr: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !(in_data.mode == MODE_BUS_WR && in_data.reg_sel == REG_DATA)
    |=> out_data.mem_req != MEM_REQ_WR)
    else $error("unexpected video memory write request");

endmodule

@@ design/vsr_sprite_mem.sv @@
module vsr_sprite_mem
  import vsr_pkg::*;
#(
  parameter int unsigned BYTES = SPRITE_RAM_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  vsr_spr_wr_t wr,
  output logic [7:0]  spr0
);

  localparam int unsigned AW = $clog2(BYTES);

  logic [7:0] mem [BYTES];
  logic [7:0] rd_r;
  logic       fwd_r;
  logic [7:0] fwd_data_r;

  // Write port and a synchronous read of entry zero
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.idx[AW-1:0]] <= wr.data;
    end
    rd_r       <= mem[0];
    fwd_data_r <= wr.data;
  end

  // Track a write to entry zero that the registered read missed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else begin
      fwd_r <= wr.en && (wr.idx == 8'd0);
    end
  end

  assign spr0 = fwd_r ? fwd_data_r : rd_r;

endmodule

@@ design/vsr_core.sv @@
module vsr_core
  import vsr_pkg::*;
#(
  parameter int unsigned BYTES = SPRITE_RAM_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  vsr_in_t     item,
  input  logic [7:0]  spr0,
  output vsr_spr_wr_t spr_wr,
  output vsr_out_t    res
);

  localparam logic [8:0] BYTES_W = 9'(BYTES);

  logic [7:0]  ctrl_r, ctrl_nxt;
  logic [7:0]  mask_r, mask_nxt;
  logic [7:0]  status_r, status_nxt;
  logic [15:0] tmp_r, tmp_nxt;
  logic [15:0] cur_r, cur_nxt;
  logic        toggle_r, toggle_nxt;
  logic [7:0]  rbuf_r, rbuf_nxt;
  logic [7:0]  ptr_r, ptr_nxt;
  logic [8:0]  line_r, line_nxt;

  logic        render_on;
  logic [15:0] addr_inc;
  logic [15:0] v;
  logic [9:0]  spr_top;
  logic [9:0]  spr_bot;
  logic        on_line;

  // Reduce the sprite pointer into the memory depth
  function automatic logic [7:0] spr_index(input logic [7:0] p);
    logic [8:0] x;
    x = {1'b0, p};
    for (int k = 0; k < 4; k++) begin
      if (x >= BYTES_W) begin
        x = x - BYTES_W;
      end
    end
    return x[7:0];
  endfunction

  assign render_on = (mask_r[3] || mask_r[4]);
  assign addr_inc  = ctrl_r[2] ? 16'd32 : 16'd1;
  assign spr_top   = {2'b00, spr0} + 10'd1;
  assign spr_bot   = spr_top + (ctrl_r[5] ? 10'd16 : 10'd8);
  assign on_line   = ({1'b0, line_r} >= spr_top) && ({1'b0, line_r} < spr_bot);

  // Copy the horizontal bits and step the vertical scroll position for the next line
  always_comb begin
    v = (cur_r & CUR_VERT_KEEP) | (tmp_r & TMP_HORIZ);
    if ((v & FINE_Y_FIELD) == FINE_Y_FIELD) begin
      v = v & TMP_FY_KEEP;
      if ((v & COARSE_Y_FIELD) == COARSE_Y_ROW29) begin
        v = (v ^ NT_VERT_FLIP) & TMP_CY_KEEP;
      end else if ((v & COARSE_Y_FIELD) == COARSE_Y_FIELD) begin
        v = v & TMP_CY_KEEP;
      end else begin
        v = v + COARSE_Y_ONE;
      end
    end else begin
      v = v + FINE_Y_ONE;
    end
  end

  // Decode one beat into next state and its result
  always_comb begin
    ctrl_nxt   = ctrl_r;
    mask_nxt   = mask_r;
    status_nxt = status_r;
    tmp_nxt    = tmp_r;
    cur_nxt    = cur_r;
    toggle_nxt = toggle_r;
    rbuf_nxt   = rbuf_r;
    ptr_nxt    = ptr_r;
    line_nxt   = line_r;
    spr_wr     = '{en: 1'b0, idx: spr_index(ptr_r), data: item.wdata};
    res        = '0;

    unique case (item.mode)
      MODE_BUS_RD: begin
        if (item.reg_sel == REG_STATUS) begin
          res.rdata  = status_r;
          status_nxt = status_r & 8'h7F;
          toggle_nxt = 1'b0;
        end else if (item.reg_sel == REG_DATA) begin
          res.rdata    = rbuf_r;
          res.mem_req  = MEM_REQ_RD;
          res.mem_addr = cur_r[13:0];
          cur_nxt      = cur_r + addr_inc;
        end
      end
      MODE_BUS_WR: begin
        unique case (item.reg_sel)
          REG_CTRL: begin
            ctrl_nxt = item.wdata;
            tmp_nxt  = (tmp_r & TMP_NT_KEEP) | {4'd0, item.wdata[1:0], 10'd0};
          end
          REG_MASK:    mask_nxt = item.wdata;
          REG_SPR_PTR: ptr_nxt  = item.wdata;
          REG_SPR_DATA: begin
            spr_wr.en = step;
            ptr_nxt   = ptr_r + 8'd1;
          end
          REG_SCROLL: begin
            toggle_nxt = !toggle_r;
            if (!toggle_r) begin
              tmp_nxt = (tmp_r & TMP_CX_KEEP) | {11'd0, item.wdata[7:3]};
            end else begin
              tmp_nxt = (tmp_r & TMP_CY_KEEP & TMP_FY_KEEP)
                      | {1'b0, item.wdata[2:0], 2'b00, item.wdata[7:3], 5'd0};
            end
          end
          REG_ADDR: begin
            toggle_nxt = !toggle_r;
            if (!toggle_r) begin
              tmp_nxt = (tmp_r & TMP_LO_KEEP) | {2'b00, item.wdata[5:0], 8'd0};
            end else begin
              tmp_nxt = (tmp_r & TMP_HI_KEEP) | {8'd0, item.wdata};
              cur_nxt = tmp_nxt;
            end
          end
          REG_DATA: begin
            res.mem_req   = MEM_REQ_WR;
            res.mem_addr  = cur_r[13:0];
            res.mem_wdata = item.wdata;
            cur_nxt       = cur_r + addr_inc;
          end
          default: ;
        endcase
      end
      MODE_MEM_RET: rbuf_nxt = item.wdata;
      MODE_FRAME: begin
        line_nxt = 9'd0;
        if (render_on) begin
          cur_nxt = tmp_r;
        end
      end
      MODE_LINE: begin
        if (render_on) begin
          if (mask_r[4]) begin
            if (item.hit_report && on_line) begin
              status_nxt[6] = 1'b1;
            end
            status_nxt[5] = item.overflow_report;
          end
          cur_nxt = v;
        end
        line_nxt = line_r + 9'd1;
      end
      MODE_VBL_START: status_nxt = status_r | 8'h80;
      MODE_VBL_END:   status_nxt = status_r & 8'h3F;
      default: ;
    endcase

    res.nmi_on_vblank = ctrl_nxt[7];
    res.line_number   = line_nxt;
  end

  // Hold state between beats, advance on each accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r   <= '0;
      mask_r   <= '0;
      status_r <= '0;
      tmp_r    <= '0;
      cur_r    <= '0;
      toggle_r <= 1'b0;
      rbuf_r   <= '0;
      ptr_r    <= '0;
      line_r   <= '0;
    end else if (step) begin
      ctrl_r   <= ctrl_nxt;
      mask_r   <= mask_nxt;
      status_r <= status_nxt;
      tmp_r    <= tmp_nxt;
      cur_r    <= cur_nxt;
      toggle_r <= toggle_nxt;
      rbuf_r   <= rbuf_nxt;
      ptr_r    <= ptr_nxt;
      line_r   <= line_nxt;
    end
  end

endmodule

@@ bench/video_scroll_register_file_checker.sv @@
`timescale 1ns / 1ps

// Watch both channels, predict each result beat and compare it field by field.
module video_scroll_register_file_checker
  import vsr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_ready,
  input  vsr_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_ready,
  input  vsr_out_t out_data,
  output int       mismatch_count,
  output int       results_pending,
  output int       results_seen
);

  // Status, mask and control bits used by the prediction
  localparam logic [7:0] STAT_VBLANK = 8'h80;
  localparam logic [7:0] STAT_SPR0   = 8'h40;
  localparam logic [7:0] STAT_OVF    = 8'h20;
  localparam logic [7:0] MASK_BG_ON  = 8'h08;
  localparam logic [7:0] MASK_SPR_ON = 8'h10;

  // Predicted register state; fine X never reaches a result, so it is not kept
  logic [7:0]  ctrl_q;
  logic [7:0]  mask_q;
  logic [7:0]  status_q;
  logic [15:0] tmp_q;
  logic [15:0] cur_q;
  logic        toggle_q;
  logic [7:0]  rd_buf_q;
  logic [7:0]  spr_ptr_q;
  // only sprite entry zero is ever read back, so hold just that one
  logic [7:0]  spr0_y_q;
  logic [8:0]  line_q;

  vsr_out_t expected_results[$];

  // Advance the predicted state by one input beat and form its result
  task automatic apply_beat(input vsr_in_t b, output vsr_out_t r);
    logic [15:0] nxt;
    int          top_line;
    int          height;
    r = '0;
    case (b.mode)
      MODE_BUS_RD: begin
        if (b.reg_sel == REG_STATUS) begin
          r.rdata  = status_q;
          status_q = status_q & ~STAT_VBLANK;
          toggle_q = 1'b0;
        end else if (b.reg_sel == REG_DATA) begin
          r.rdata    = rd_buf_q;
          r.mem_req  = MEM_REQ_RD;
          r.mem_addr = cur_q[13:0];
          cur_q      = cur_q + (ctrl_q[2] ? 16'd32 : 16'd1);
        end
      end
      MODE_BUS_WR: begin
        case (b.reg_sel)
          REG_CTRL: begin
            ctrl_q = b.wdata;
            tmp_q  = (tmp_q & TMP_NT_KEEP) | {4'b0, b.wdata[1:0], 10'b0};
          end
          REG_MASK: mask_q = b.wdata;
          REG_SPR_PTR: spr_ptr_q = b.wdata;
          REG_SPR_DATA: begin
            if (spr_ptr_q == 8'd0) spr0_y_q = b.wdata;
            spr_ptr_q = spr_ptr_q + 8'd1;
          end
          REG_SCROLL: begin
            toggle_q = ~toggle_q;
            if (toggle_q) begin
              tmp_q = (tmp_q & TMP_CX_KEEP) | {11'b0, b.wdata[7:3]};
            end else begin
              tmp_q = (tmp_q & TMP_CY_KEEP) | {6'b0, b.wdata[7:3], 5'b0};
              tmp_q = (tmp_q & TMP_FY_KEEP) | {1'b0, b.wdata[2:0], 12'b0};
            end
          end
          REG_ADDR: begin
            toggle_q = ~toggle_q;
            if (toggle_q) begin
              tmp_q = (tmp_q & TMP_LO_KEEP) | {2'b0, b.wdata[5:0], 8'b0};
            end else begin
              tmp_q = (tmp_q & TMP_HI_KEEP) | {8'b0, b.wdata};
              cur_q = tmp_q;
            end
          end
          REG_DATA: begin
            r.mem_req   = MEM_REQ_WR;
            r.mem_addr  = cur_q[13:0];
            r.mem_wdata = b.wdata;
            cur_q       = cur_q + (ctrl_q[2] ? 16'd32 : 16'd1);
          end
          default: ;
        endcase
      end
      MODE_MEM_RET: rd_buf_q = b.wdata;
      MODE_FRAME: begin
        line_q = 9'd0;
        if ((mask_q & (MASK_BG_ON | MASK_SPR_ON)) != 8'd0) cur_q = tmp_q;
      end
      MODE_LINE: begin
        if ((mask_q & (MASK_BG_ON | MASK_SPR_ON)) != 8'd0) begin
          // sprite flags only move while sprites are shown
          if ((mask_q & MASK_SPR_ON) != 8'd0) begin
            top_line = int'(spr0_y_q) + 1;
            height   = ctrl_q[5] ? 16 : 8;
            if (b.hit_report && int'(line_q) >= top_line &&
                int'(line_q) < top_line + height)
              status_q = status_q | STAT_SPR0;
            if (b.overflow_report) status_q = status_q | STAT_OVF;
            else status_q = status_q & ~STAT_OVF;
          end
          // copy horizontal bits, then step fine Y and coarse Y
          nxt = (cur_q & CUR_VERT_KEEP) | (tmp_q & TMP_HORIZ);
          if ((nxt & FINE_Y_FIELD) == FINE_Y_FIELD) begin
            nxt = nxt & TMP_FY_KEEP;
            if ((nxt & COARSE_Y_FIELD) == COARSE_Y_ROW29)
              nxt = (nxt ^ NT_VERT_FLIP) & TMP_CY_KEEP;
            else if ((nxt & COARSE_Y_FIELD) == COARSE_Y_FIELD)
              nxt = nxt & TMP_CY_KEEP;
            else
              nxt = nxt + COARSE_Y_ONE;
          end else begin
            nxt = nxt + FINE_Y_ONE;
          end
          cur_q = nxt;
        end
        line_q = line_q + 9'd1;
      end
      MODE_VBL_START: status_q = status_q | STAT_VBLANK;
      MODE_VBL_END: status_q = status_q & ~(STAT_VBLANK | STAT_SPR0);
      default: ;
    endcase
    r.nmi_on_vblank = ctrl_q[7];
    r.line_number   = line_q;
  endtask

  task automatic check_field(input string name, input int unsigned want_v,
                             input int unsigned got_v);
    if (want_v != got_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
      mismatch_count++;
    end
  endtask

  // Retire the oldest expectation first: a result never belongs to the beat
  // accepted on the same edge
  always @(posedge clk) begin : track
    vsr_out_t want;
    if (!rst_n) begin
      ctrl_q    = '0;
      mask_q    = '0;
      status_q  = '0;
      tmp_q     = '0;
      cur_q     = '0;
      toggle_q  = 1'b0;
      rd_buf_q  = '0;
      spr_ptr_q = '0;
      spr0_y_q  = '0;
      line_q    = '0;
      expected_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result beat with no expectation waiting");
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("rdata", want.rdata, out_data.rdata);
          check_field("mem_req", want.mem_req, out_data.mem_req);
          check_field("mem_addr", want.mem_addr, out_data.mem_addr);
          check_field("mem_wdata", want.mem_wdata, out_data.mem_wdata);
          check_field("nmi_on_vblank", want.nmi_on_vblank, out_data.nmi_on_vblank);
          check_field("line_number", want.line_number, out_data.line_number);
          results_seen++;
        end
      end
      if (in_valid && in_ready) begin
        apply_beat(in_data, want);
        expected_results.push_back(want);
      end
    end
    results_pending = expected_results.size();
  end

endmodule

@@ bench/video_scroll_register_file_tb.sv @@
`timescale 1ns / 1ps

module video_scroll_register_file_tb;
  import vsr_pkg::*;

  // Mode code with no meaning: the block must leave its state alone
  localparam logic [2:0] MODE_UNUSED  = 3'd7;
  localparam int         RANDOM_BEATS = 400;
  localparam int         LONG_LINES   = 80;
  localparam int         QUIET_LIMIT  = 500;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  vsr_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  vsr_out_t out_data;

  int mismatch_count;
  int results_pending;
  int results_seen;
  int beats_sent;
  int frames_run;
  int quiet_cycles;
  int stall_left;
  int random_start;
  bit allow_idle = 1'b1;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  video_scroll_register_file i_dut (
    .clk,
    .rst_n,
    .in_valid,
    .in_ready,
    .in_data,
    .out_valid,
    .out_ready,
    .out_data
  );

  video_scroll_register_file_checker i_checker (
    .clk,
    .rst_n,
    .in_valid,
    .in_ready,
    .in_data,
    .out_valid,
    .out_ready,
    .out_data,
    .mismatch_count,
    .results_pending,
    .results_seen
  );

  // Stall the result side in random bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (allow_idle && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 6);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Abort when neither channel moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Offer one input beat, maybe after an idle burst, and hold it until taken
  task automatic put(input logic [2:0] m, input logic [2:0] s, input logic [7:0] d,
                     input logic h, input logic o);
    vsr_in_t b;
    b.mode            = m;
    b.reg_sel         = s;
    b.wdata           = d;
    b.hit_report      = h;
    b.overflow_report = o;
    if (allow_idle && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    beats_sent++;
  endtask

  task automatic wr(input logic [2:0] s, input logic [7:0] d);
    put(MODE_BUS_WR, s, d, 1'b0, 1'b0);
  endtask

  task automatic rd(input logic [2:0] s);
    put(MODE_BUS_RD, s, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
        1'($urandom_range(0, 1)));
  endtask

  task automatic evt(input logic [2:0] m, input logic h, input logic o);
    put(m, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)), h, o);
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: write sprite entry zero before any scanline can read it
    wr(REG_SPR_PTR, 8'h00);
    wr(REG_SPR_DATA, 8'h00);
    wr(REG_CTRL, 8'hFF);
    wr(REG_MASK, 8'hFF);
    wr(REG_SCROLL, 8'hFF);
    wr(REG_SCROLL, 8'h00);
    wr(REG_ADDR, 8'hFF);
    wr(REG_ADDR, 8'hFF);
    wr(REG_DATA, 8'hFF);
    rd(REG_DATA);
    put(MODE_MEM_RET, REG_CTRL, 8'hFF, 1'b1, 1'b1);
    rd(REG_DATA);
    rd(REG_CTRL);
    rd(REG_SPR_DATA);
    wr(REG_STATUS, 8'hFF);
    evt(MODE_VBL_START, 1'b0, 1'b0);
    rd(REG_STATUS);
    evt(MODE_VBL_END, 1'b0, 1'b0);
    evt(MODE_FRAME, 1'b0, 1'b0);
    evt(MODE_LINE, 1'b1, 1'b1);
    evt(MODE_LINE, 1'b1, 1'b0);
    rd(REG_STATUS);
    put(MODE_UNUSED, 3'd7, 8'hFF, 1'b1, 1'b1);
    wr(REG_CTRL, 8'h00);
    wr(REG_ADDR, 8'h00);
    wr(REG_ADDR, 8'h00);
    wr(REG_DATA, 8'h00);

    // One long frame with rendering on
    wr(REG_MASK, 8'h18 | 8'($urandom_range(0, 255)));
    evt(MODE_FRAME, 1'b0, 1'b0);
    repeat (LONG_LINES)
      evt(MODE_LINE, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    frames_run++;

    // Random: mostly well-formed register sequences and frames, some noise
    random_start = beats_sent;
    while (beats_sent - random_start < RANDOM_BEATS) begin
      allow_idle = (beats_sent - random_start) < RANDOM_BEATS * 4 / 5;
      case ($urandom_range(0, 9))
        0, 1: begin
          evt(MODE_VBL_END, 1'b0, 1'b0);
          evt(MODE_FRAME, 1'b0, 1'b0);
          repeat ($urandom_range(1, 60))
            evt(MODE_LINE, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
          evt(MODE_VBL_START, 1'b0, 1'b0);
          rd(REG_STATUS);
          frames_run++;
        end
        2: begin
          if ($urandom_range(0, 1)) rd(REG_STATUS);
          wr(REG_SCROLL, 8'($urandom_range(0, 255)));
          wr(REG_SCROLL, 8'($urandom_range(0, 255)));
        end
        3: begin
          if ($urandom_range(0, 1)) rd(REG_STATUS);
          wr(REG_ADDR, 8'($urandom_range(0, 255)));
          wr(REG_ADDR, 8'($urandom_range(0, 255)));
          repeat ($urandom_range(1, 4)) begin
            if ($urandom_range(0, 1)) begin
              wr(REG_DATA, 8'($urandom_range(0, 255)));
            end else begin
              rd(REG_DATA);
              evt(MODE_MEM_RET, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
          end
        end
        4: begin
          wr(REG_CTRL, 8'($urandom_range(0, 255)));
          wr(REG_MASK, $urandom_range(0, 3) != 0 ? 8'h08 << $urandom_range(0, 1) |
             8'($urandom_range(0, 255)) : 8'($urandom_range(0, 255)) & 8'hE7);
        end
        5: begin
          wr(REG_SPR_PTR, $urandom_range(0, 3) == 0 ? 8'h00 : 8'($urandom_range(0, 255)));
          // keep sprite zero near the top now and then so hits can land
          repeat ($urandom_range(1, 4))
            wr(REG_SPR_DATA, $urandom_range(0, 1) ? 8'($urandom_range(0, 40))
                                                   : 8'($urandom_range(0, 255)));
        end
        6: begin
          evt(MODE_VBL_START, 1'b0, 1'b0);
          rd(REG_STATUS);
          rd(REG_STATUS);
          evt(MODE_VBL_END, 1'b0, 1'b0);
        end
        7, 8: begin
          put(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
              8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)));
        end
        default: begin
          // broken sequences: half a two-phase write, or a read never answered
          case ($urandom_range(0, 2))
            0: wr(REG_SCROLL, 8'($urandom_range(0, 255)));
            1: wr(REG_ADDR, 8'($urandom_range(0, 255)));
            default: rd(REG_DATA);
          endcase
        end
      endcase
    end
    in_valid <= 1'b0;

    // Drain, then wait for any stray beat
    wait (results_pending == 0);
    repeat (10) @(posedge clk);
    $display("Covered %0d input beats over %0d frames; %0d result beats compared",
             beats_sent, frames_run, results_seen);
    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

@@ sim.f @@
design/vsr_pkg.sv
design/vsr_sprite_mem.sv
design/vsr_core.sv
design/video_scroll_register_file.sv
bench/video_scroll_register_file_checker.sv
bench/video_scroll_register_file_tb.sv
